@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define WBPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same, but a condition must imply a property.
`define WBPS_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

@@ rtl/wbps_pkg.sv @@
// ---------------------------------------------------------------------------
// wbps_pkg
// Types and constants of the wildcard byte pattern search.
// ---------------------------------------------------------------------------
package wbps_pkg;

	localparam int unsigned ADDR_W    = 16;
	localparam int unsigned PAT_W     = 64;
	localparam int unsigned LEN_W     = 5;
	localparam int unsigned SEEN_W    = 17;
	localparam int unsigned CFG_IDX_W = 3;

	typedef logic [7:0]        byte_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [SEEN_W-1:0] seen_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

	localparam seen_t SEEN_MAX = '1;

endpackage

@@ rtl/wbps_match.sv @@
// ---------------------------------------------------------------------------
// wbps_match
// Parallel wildcard compare of the byte window against the pattern.
// ---------------------------------------------------------------------------
module wbps_match import wbps_pkg::*; #(
	parameter int unsigned MAX_PATTERN = 16
) (
	input  byte_t              win [MAX_PATTERN],  // entry 0 newest
	input  byte_t              pat [MAX_PATTERN],
	input  logic [MAX_PATTERN-1:0] care,
	input  len_t               len,                // already clamped, 1..MAX_PATTERN
	output logic               hit
);

	localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [MAX_PATTERN-1:0] ok;

	// pattern byte k lines up with window entry len-1-k
	always_comb begin
		len_t pos;
		pos = '0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			pos   = len - len_t'(k) - len_t'(1);
			ok[k] = (len_t'(k) >= len) || !care[k] || (win[pos[IDX_W-1:0]] == pat[k]);
		end
	end

	assign hit = &ok;

endmodule

@@ rtl/wildcard_byte_pattern_search_top.sv @@
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_search_top
// Streams a memory region byte by byte and reports the first wildcard match.
// ---------------------------------------------------------------------------
// One byte is taken every cycle while the result register is free or being
// drained; the compare of all pattern bytes against the shifted window and the
// address add sit between the window registers and the result register, so a
// byte's result appears the cycle after acceptance.
// A region yields one result: found with the match start address, or, on
// tlast without a match, not-found with address 0. Bytes after a match are
// swallowed until tlast. A match must lie wholly inside the streamed bytes.
// Configure only while the stream is idle.
module wildcard_byte_pattern_search_top import wbps_pkg::*; #(
	parameter int unsigned MAX_PATTERN = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]     cfg_data,
	// byte stream in
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic                 s_tlast,   // last_byte
	// result out
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [15:0] match_address
	output logic                 m_tuser    // [0] found
);

`include "assert_macros.svh"

	// configuration registers
	addr_t            start_q;
	logic [PAT_W-1:0] pat_low_q;
	logic [PAT_W-1:0] pat_high_q;
	logic [15:0]      care_q;
	len_t             len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '1;
			len_q      <= len_t'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_ADDRESS:  start_q    <= cfg_data[ADDR_W-1:0];
				REG_PATTERN_LOW:    pat_low_q  <= cfg_data;
				REG_PATTERN_HIGH:   pat_high_q <= cfg_data;
				REG_CARE_MASK:      care_q     <= cfg_data[15:0];
				REG_PATTERN_LENGTH: len_q      <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// search state
	byte_t win_q [MAX_PATTERN];
	seen_t seen_q;
	logic  done_q;

	// result register
	logic  m_valid_q;
	logic  found_q;
	addr_t addr_q;

	byte_t                  win_nx [MAX_PATTERN];
	byte_t                  pat    [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] care;
	len_t                   len_use;
	seen_t                  seen_nx;
	logic                   hit;
	logic                   s_fire;
	logic                   match;
	logic                   res_load;
	addr_t                  match_addr;

	assign s_tready = !m_valid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	always_comb begin
		logic [127:0] pat_all;
		pat_all = {pat_high_q, pat_low_q};
		for (int k = 0; k < MAX_PATTERN; k++) begin
			pat[k]  = pat_all[8*k +: 8];
			care[k] = care_q[k];
		end
		win_nx[0] = s_tdata;
		for (int i = 1; i < MAX_PATTERN; i++)
			win_nx[i] = win_q[i-1];
	end

	// zero counts as one, anything above the window depth is clamped
	always_comb begin
		if (len_q == '0)
			len_use = len_t'(1);
		else if (len_q > len_t'(MAX_PATTERN))
			len_use = len_t'(MAX_PATTERN);
		else
			len_use = len_q;
	end

	assign seen_nx = (seen_q == SEEN_MAX) ? seen_q : seen_q + seen_t'(1);

	wbps_match #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_match (
		.win  (win_nx),
		.pat  (pat),
		.care (care),
		.len  (len_use),
		.hit  (hit)
	);

	assign match      = hit && (seen_nx >= seen_t'(len_use));
	assign match_addr = start_q + addr_t'(seen_nx - seen_t'(len_use));
	assign res_load   = s_fire && !done_q && (match || s_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN; i++)
				win_q[i] <= '0;
			seen_q <= '0;
			done_q <= 1'b0;
		end else if (s_fire) begin
			if (s_tlast) begin
				for (int i = 0; i < MAX_PATTERN; i++)
					win_q[i] <= '0;
				seen_q <= '0;
				done_q <= 1'b0;
			end else if (!done_q) begin
				win_q  <= win_nx;
				seen_q <= seen_nx;
				done_q <= match;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			found_q <= match;
			addr_q  <= match ? match_addr : '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = addr_q;
	assign m_tuser  = found_q;

	`WBPS_ASSERT_IMP(a_done_mutes, s_fire && done_q, !res_load,
		"result produced after a match in the same region")
	`WBPS_ASSERT(a_match_sets_done, s_fire && match && !done_q && !s_tlast |=> done_q,
		"match did not latch search_done")
	`WBPS_ASSERT(a_last_clears, s_fire && s_tlast |=> (seen_q == '0) && !done_q,
		"region end did not clear the search state")
	`WBPS_ASSERT_IMP(a_miss_zero_addr, m_valid_q && !found_q, addr_q == '0,
		"not-found result with non-zero address")

endmodule

@@ verif/wbps_search_checker.sv @@
// ---------------------------------------------------------------------------
// wbps_search_checker
// Follows register writes and both streams of the pattern search, keeps its
// own copy of the search state and compares each report with the predicted one.
// ---------------------------------------------------------------------------
module wbps_search_checker import wbps_pkg::*; #(
	parameter int unsigned MAX_PATTERN = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic                 s_tlast,   // last_byte
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [15:0]          m_tdata,   // [15:0] match_address
	input  logic                 m_tuser,   // [0] found
	output int                   errors,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic  found;
		addr_t addr;
	} report_t;

	addr_t              base_addr;
	logic [2*PAT_W-1:0] pattern;
	logic [15:0]        care;
	len_t               pat_len;

	byte_t              history [MAX_PATTERN];
	seen_t              seen;
	logic               reported;

	report_t            reports [$];
	int                 error_tally;

	task automatic clear_region();
		int i;
		for (i = 0; i < MAX_PATTERN; i++)
			history[i] = '0;
		seen     = '0;
		reported = 1'b0;
	endtask

	task automatic advance_search(input byte_t data, input logic last);
		int      width;
		int      i;
		logic    hit;
		report_t r;
		if (!reported) begin
			width = (pat_len == 0) ? 1 : (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
			for (i = MAX_PATTERN - 1; i > 0; i--)
				history[i] = history[i - 1];
			history[0] = data;
			if (seen != SEEN_MAX)
				seen++;
			// no window is tested until it lies wholly inside the region
			hit = (int'(seen) >= width);
			for (i = 0; i < width; i++)
				if (care[i] && history[width - 1 - i] != pattern[8*i +: 8])
					hit = 1'b0;
			if (hit) begin
				r.found = 1'b1;
				r.addr  = addr_t'(int'(base_addr) + int'(seen) - width);
				reports.insert(reports.size(), r);
				reported = 1'b1;
			end else if (last) begin
				r.found = 1'b0;
				r.addr  = '0;
				reports.insert(reports.size(), r);
			end
		end
		if (last)
			clear_region();
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			base_addr   = '0;
			pattern     = '0;
			care        = '1;
			pat_len     = len_t'(1);
			clear_region();
			reports.delete();
			error_tally = 0;
			errors      <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				case (cfg_index)
					REG_START_ADDRESS:  base_addr = cfg_data[ADDR_W-1:0];
					REG_PATTERN_LOW:    pattern[PAT_W-1:0] = cfg_data;
					REG_PATTERN_HIGH:   pattern[2*PAT_W-1:PAT_W] = cfg_data;
					REG_CARE_MASK:      care = cfg_data[15:0];
					REG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			if (s_tvalid && s_tready)
				advance_search(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (reports.size() == 0) begin
					error_tally++;
					$display("%0t: unexpected report: expected none, actual found %0b address %h",
						$time, m_tuser, m_tdata);
				end else begin
					want = reports.pop_front();
					if (m_tuser !== want.found) begin
						error_tally++;
						$display("%0t: found: expected %0b, actual %0b",
							$time, want.found, m_tuser);
					end
					if (m_tdata !== want.addr) begin
						error_tally++;
						$display("%0t: match_address: expected %h, actual %h",
							$time, want.addr, m_tdata);
					end
				end
			end
			errors      <= error_tally;
			outstanding <= reports.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Drives byte regions and register settings into the pattern search, with
// random gaps and back-pressure, and reports the verdict of the checker.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import wbps_pkg::*;

	localparam int TOTAL_BYTES   = 1050;
	localparam int PHASE2_AT     = 350;
	localparam int PHASE3_AT     = 700;
	localparam int LONG_HOLD     = 300;
	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 4;

	// an index past the register list; writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PAT_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;   // [7:0] data_byte
	logic                 s_tlast   = 1'b0; // last_byte
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [15:0]          m_tdata;          // [15:0] match_address
	logic                 m_tuser;          // [0] found

	int errors;
	int outstanding;

	int   send_idle_pct = 33;
	int   recv_idle_pct = 80;
	logic hold_asked    = 1'b0;
	logic hold_given    = 1'b0;
	int   hold_left     = 0;
	int   bytes_sent    = 0;

	// stimulus-side copy of the pattern, used to plant matches
	logic [2*PAT_W-1:0] cur_pat = '0;
	int                 cur_len = 1;

	always #5 clk = ~clk;

	wildcard_byte_pattern_search_top dut (.*);

	wbps_search_checker search_check (.*);

	// receiver: random stalls, plus one long hold-off to fill the block
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked && !hold_given) begin
			m_tready   <= 1'b0;
			hold_left  <= LONG_HOLD;
			hold_given <= 1'b1;
		end else
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: errors");
		$finish;
	end

	task automatic send_byte(input byte_t data, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_region(input byte_t bytes[$]);
		int i;
		for (i = 0; i < bytes.size(); i++)
			send_byte(bytes[i], i == bytes.size() - 1);
		bytes_sent += bytes.size();
	endtask

	// let every report drain and the pipe empty before touching registers
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic configure(input addr_t addr, input logic [PAT_W-1:0] lo,
			input logic [PAT_W-1:0] hi, input logic [15:0] mask, input len_t len);
		logic [PAT_W-1:0] junk;
		settle();
		junk = {$urandom, $urandom};
		write_reg(REG_START_ADDRESS, {junk[PAT_W-1:ADDR_W], addr});
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_CARE_MASK, {junk[PAT_W-1:16], mask});
		write_reg(REG_PATTERN_LENGTH, {junk[PAT_W-1:LEN_W], len});
		write_reg(REG_SPARE, {$urandom, $urandom});
		cfg_we  <= 1'b0;
		cur_pat = {hi, lo};
		cur_len = (len == 0) ? 1 : (len > 16) ? 16 : int'(len);
	endtask

	initial begin : stimulus
		byte_t            region[$];
		byte_t            b;
		int               regions_left;
		int               rlen;
		int               at;
		int               k;
		len_t             len;
		logic [15:0]      mask;
		addr_t            addr;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one-byte pattern 0x00; bytes after the match are swallowed
		region = '{8'h55, 8'h00, 8'hAA};
		send_region(region);

		// match on the last byte, address wraps past 0xFFFF
		configure(16'hFFFE, 64'h0000_0000_00BE_ADDE, {$urandom, $urandom}, 16'hFFFF, 5'd3);
		region = '{8'hDE, 8'hAD, 8'hDE, 8'hAD, 8'hBE};
		send_region(region);
		region = '{8'h01, 8'h02, 8'h03};
		send_region(region);

		// all wildcards: region shorter than the pattern, then exactly as long
		configure(16'h1234, {$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd3);
		region = '{8'h11, 8'h22};
		send_region(region);
		region = '{8'h11, 8'h22, 8'h33};
		send_region(region);

		// length zero behaves as one
		configure(16'hFFFF, 64'h0000_0000_0000_00FF, 64'h0, 16'hFFFF, 5'd0);
		region = '{8'hFF};
		send_region(region);

		// wildcard in the middle
		configure(16'h0000, 64'h0000_0000_00FF_5A00, 64'h0, 16'h0005, 5'd3);
		region = '{8'h00, 8'h7E, 8'hFF};
		send_region(region);

		regions_left = 0;
		while (bytes_sent < TOTAL_BYTES) begin
			if (regions_left == 0) begin
				if (bytes_sent >= PHASE3_AT) begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end else if (bytes_sent >= PHASE2_AT) begin
					send_idle_pct = 80;
					recv_idle_pct <= 33;
				end
				case ($urandom_range(0, 5))
					0:       len = 5'd0;
					1:       len = 5'd16;
					2:       len = len_t'($urandom_range(17, 31));
					default: len = len_t'($urandom_range(1, 16));
				endcase
				case ($urandom_range(0, 3))
					0:       mask = 16'hFFFF;
					1:       mask = 16'h0000;
					default: mask = 16'($urandom);
				endcase
				case ($urandom_range(0, 3))
					0:       addr = '0;
					1:       addr = '1;
					default: addr = addr_t'($urandom);
				endcase
				configure(addr, {$urandom, $urandom}, {$urandom, $urandom}, mask, len);
				// receiver holds off while the sender keeps going
				if (bytes_sent >= PHASE3_AT)
					hold_asked <= 1'b1;
				regions_left = $urandom_range(2, 8);
			end

			rlen = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, cur_len + 20);
			region.delete();
			for (k = 0; k < rlen; k++) begin
				at = $urandom_range(0, cur_len - 1);
				b  = ($urandom_range(0, 1) == 0) ? byte_t'($urandom) : cur_pat[8*at +: 8];
				region.insert(region.size(), b);
			end
			if ($urandom_range(0, 99) < 65) begin
				at = $urandom_range(0, rlen - 1);
				for (k = 0; k < cur_len && at + k < rlen; k++)
					region[at + k] = cur_pat[8*k +: 8];
				// now and then spoil the planted copy
				if ($urandom_range(0, 4) == 0)
					region[at] = ~region[at];
			end
			send_region(region);
			regions_left--;
		end

		settle();
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
